FILE: rtl/pmb_pkg.sv
// Shared types, constants and codes of the priority mailbox.
`default_nettype none

package pmb_pkg;

  // Defaults of the top-level parameters
  localparam int QueueDepthDef      = 256;
  localparam int PriorityLevelsDef  = 64;
  localparam int PayloadWidthDef    = 32;
  localparam int InflightLimitDef   = 255;

  // Fixed field widths of the channels
  localparam int PayloadPortW = 32;
  localparam int PriorityInW  = 8;
  localparam int PriorityOutW = 6;
  localparam int QueuedW      = 9;
  localparam int RunningW     = 8;
  localparam int ActiveW      = 10;
  localparam int CfgIndexW    = 3;
  localparam int CfgValueW    = 9;

  // Highest priority level a request may ask for
  localparam int PrioClampTop = 63;

  localparam logic [ActiveW-1:0] ActiveMax = {ActiveW{1'b1}};

  // Request function codes
  localparam logic FuncEnqueue  = 1'b0;
  localparam logic FuncComplete = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] RegDispatcherReady = 3'd0;
  localparam logic [CfgIndexW-1:0] RegSerialMode      = 3'd1;
  localparam logic [CfgIndexW-1:0] RegMaxInflight     = 3'd2;
  localparam logic [CfgIndexW-1:0] RegMaxQueueSize    = 3'd3;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_READY = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    logic                          func;
    logic [PayloadPortW-1:0]       msg_payload;
    logic signed [PriorityInW-1:0] msg_priority;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic                    dispatched;
    logic [PayloadPortW-1:0] out_payload;
    logic [PriorityOutW-1:0] out_priority;
    logic [QueuedW-1:0]      queued_count;
    logic [RunningW-1:0]     running_count;
    logic                    idle_flag;
  } out_item_t;

  typedef struct packed {
    logic [CfgIndexW-1:0] index;
    logic [CfgValueW-1:0] value;
  } cfg_write_t;

endpackage

`default_nettype wire

FILE: rtl/pmb_stream_if.sv
// Valid/ready channel interface carrying one payload type.
`default_nettype none

interface pmb_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/pmb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pmb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/priority_mailbox_with_inflight_limit.sv
// Priority mailbox with FIFO levels, a waiting limit and an in-flight limit.
//
// Channels: in_i takes requests (enqueue a tagged message at a priority, or
// complete a dispatched message); out_o returns exactly one result per request
// with a status, an optional dispatch (tag and level) and the counts after it;
// cfg_i writes the four configuration registers and is always ready.
// Each level is a linked list over a shared slot store; free slots circulate
// through a ring of slot numbers. All lists live in synchronous RAMs.
// Steps: a request that touches no list goes straight to S_DONE; a queued enqueue
// passes S_PUSH_RD and S_PUSH_WR; a completion that dispatches from a list passes
// S_POP_HEAD, S_POP_SLOT and S_POP_WR; a queued enqueue with dispatch does both.
// The pops follow dependent RAM reads: head entry, then slot payload and link.
// One request is processed at a time; the next request is accepted once the
// previous result sits in the output register, even if out_o is stalled.
// A stalled out_o holds the result and blocks only the finish of the next one.
// Reset empties all levels, zeroes the counts and loads the register defaults
// (ready, serial mode, limit 1, queue size 256); no RAM clearing pass runs.
`default_nettype none

module priority_mailbox_with_inflight_limit
  import pmb_pkg::*;
#(
  parameter int QUEUE_DEPTH        = QueueDepthDef,
  parameter int PRIORITY_LEVELS    = PriorityLevelsDef,
  parameter int PAYLOAD_WIDTH      = PayloadWidthDef,
  parameter int INFLIGHT_LIMIT_MAX = InflightLimitDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pmb_stream_if.sink    in_i,
  pmb_stream_if.source  out_o,
  pmb_stream_if.sink    cfg_i
);

  localparam int SlotW   = $clog2(QUEUE_DEPTH);
  localparam int LvlW    = $clog2(PRIORITY_LEVELS);
  localparam int WaitW   = $clog2(QUEUE_DEPTH + 1);
  localparam int PrioTop = (PrioClampTop < PRIORITY_LEVELS - 1) ? PrioClampTop
                                                                : PRIORITY_LEVELS - 1;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_PUSH_RD  = 7'b0000010,
    S_PUSH_WR  = 7'b0000100,
    S_POP_HEAD = 7'b0001000,
    S_POP_SLOT = 7'b0010000,
    S_POP_WR   = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  // Control state
  state_e                   state_q, state_d;
  logic                     disp_ready_q, serial_q;
  logic [RunningW-1:0]      max_inflight_q;
  logic [QueuedW-1:0]       max_qsize_q;
  logic [PRIORITY_LEVELS-1:0] nonempty_q, nonempty_d;
  logic [SlotW-1:0]         rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic                     ring_full_q, ring_full_d;
  logic [WaitW-1:0]         waiting_q, waiting_d;
  logic [RunningW-1:0]      inflight_q, inflight_d;
  logic [ActiveW-1:0]       active_q, active_d;
  logic                     out_valid_q, out_valid_d;

  // Datapath state
  logic [LvlW-1:0]          prio_q, prio_d;
  logic [PAYLOAD_WIDTH-1:0] payload_q, payload_d;
  logic                     disp_pend_q, disp_pend_d;
  logic [LvlW-1:0]          lvl_q, lvl_d;
  logic                     is_tail_q, is_tail_d;
  status_e                  res_status_q, res_status_d;
  logic                     res_disp_q, res_disp_d;
  logic [PAYLOAD_WIDTH-1:0] res_payload_q, res_payload_d;
  logic [LvlW-1:0]          res_lvl_q, res_lvl_d;
  out_item_t                out_data_q, out_data_d;

  // RAM ports
  logic                     pay_we, next_we, head_we, tail_we, ring_we;
  logic [SlotW-1:0]         pay_waddr, next_waddr, ring_waddr;
  logic [LvlW-1:0]          head_waddr, tail_waddr;
  logic [SlotW-1:0]         next_wdata, head_wdata, tail_wdata, ring_wdata;
  logic [SlotW-1:0]         pay_raddr, next_raddr, ring_raddr;
  logic [LvlW-1:0]          head_raddr, tail_raddr;
  logic [PAYLOAD_WIDTH-1:0] pay_rdata;
  logic [SlotW-1:0]         next_rdata, head_rdata, tail_rdata, ring_rdata;

  // Request decode helpers
  logic [LvlW-1:0]            in_lvl;
  logic [PRIORITY_LEVELS-1:0] le_mask;
  logic [LvlW-1:0]            lvl_first;
  logic [RunningW-1:0]        mi_eff, inflight_dec;
  logic [QueuedW-1:0]         qs_eff;
  logic                       run_ok_cur, run_ok_dec, queue_full;
  logic [ActiveW-1:0]         act_inc, act_dec;
  logic [SlotW-1:0]           slot_new, rd_ptr_inc, wr_ptr_inc;
  logic                       idle_now;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // Clamp the requested level to the valid range
  always_comb begin
    if (in_i.data.msg_priority[PriorityInW-1]) begin
      in_lvl = '0;
    end else if (int'(in_i.data.msg_priority) > PrioTop) begin
      in_lvl = LvlW'(PrioTop);
    end else begin
      in_lvl = LvlW'(in_i.data.msg_priority);
    end
  end

  always_comb begin
    for (int i = 0; i < PRIORITY_LEVELS; i++) begin
      le_mask[i] = (i <= int'(in_lvl));
    end
  end

  // Most urgent non-empty level
  always_comb begin
    lvl_first = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (nonempty_q[i]) begin
        lvl_first = LvlW'(i);
      end
    end
  end

  assign mi_eff       = (max_inflight_q == '0) ? RunningW'(1) : max_inflight_q;
  assign qs_eff       = (max_qsize_q == '0) ? QueuedW'(1) : max_qsize_q;
  assign inflight_dec = (inflight_q == '0) ? '0 : inflight_q - 1'b1;
  assign run_ok_cur   = serial_q ? (inflight_q == '0)
                                 : (inflight_q < mi_eff) &&
                                   (int'(inflight_q) < INFLIGHT_LIMIT_MAX);
  assign run_ok_dec   = serial_q ? (inflight_dec == '0)
                                 : (inflight_dec < mi_eff) &&
                                   (int'(inflight_dec) < INFLIGHT_LIMIT_MAX);
  assign queue_full   = (int'(waiting_q) >= int'(qs_eff)) ||
                        (int'(waiting_q) >= QUEUE_DEPTH);
  assign act_inc      = (active_q == ActiveMax) ? active_q : active_q + 1'b1;
  assign act_dec      = (active_q == '0) ? '0 : active_q - 1'b1;
  assign rd_ptr_inc   = (rd_ptr_q == SlotW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign wr_ptr_inc   = (wr_ptr_q == SlotW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
  // Ring entries not yet written are taken to hold their own slot number
  assign slot_new     = (ring_full_q || (rd_ptr_q < wr_ptr_q)) ? ring_rdata : rd_ptr_q;
  assign idle_now     = (active_q == '0) && (waiting_q == '0) && (inflight_q == '0);

  // RAM read addresses
  assign ring_raddr = rd_ptr_q;
  assign head_raddr = lvl_first;
  assign tail_raddr = (state_q == S_PUSH_RD) ? prio_q : lvl_first;
  assign pay_raddr  = head_rdata;
  assign next_raddr = head_rdata;

  always_comb begin
    state_d       = state_q;
    nonempty_d    = nonempty_q;
    rd_ptr_d      = rd_ptr_q;
    wr_ptr_d      = wr_ptr_q;
    ring_full_d   = ring_full_q;
    waiting_d     = waiting_q;
    inflight_d    = inflight_q;
    active_d      = active_q;
    out_valid_d   = out_valid_q;
    prio_d        = prio_q;
    payload_d     = payload_q;
    disp_pend_d   = disp_pend_q;
    lvl_d         = lvl_q;
    is_tail_d     = is_tail_q;
    res_status_d  = res_status_q;
    res_disp_d    = res_disp_q;
    res_payload_d = res_payload_q;
    res_lvl_d     = res_lvl_q;
    out_data_d    = out_data_q;

    pay_we     = 1'b0;
    next_we    = 1'b0;
    head_we    = 1'b0;
    tail_we    = 1'b0;
    ring_we    = 1'b0;
    pay_waddr  = slot_new;
    next_waddr = tail_rdata;
    next_wdata = slot_new;
    head_waddr = prio_q;
    head_wdata = slot_new;
    tail_waddr = prio_q;
    tail_wdata = slot_new;
    ring_waddr = wr_ptr_q;
    ring_wdata = head_rdata;

    // Drop the result once taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          payload_d     = PAYLOAD_WIDTH'(in_i.data.msg_payload);
          prio_d        = in_lvl;
          disp_pend_d   = 1'b0;
          res_status_d  = STATUS_OK;
          res_disp_d    = 1'b0;
          res_payload_d = '0;
          res_lvl_d     = '0;
          state_d       = S_DONE;
          if (in_i.data.func == FuncEnqueue) begin
            if (!disp_ready_q) begin
              res_status_d = STATUS_NOT_READY;
            end else if ((waiting_q == '0) && run_ok_cur) begin
              active_d      = act_inc;
              inflight_d    = inflight_q + 1'b1;
              res_disp_d    = 1'b1;
              res_payload_d = PAYLOAD_WIDTH'(in_i.data.msg_payload);
              res_lvl_d     = in_lvl;
            end else if (queue_full) begin
              res_status_d = STATUS_OVERFLOW;
            end else begin
              active_d = act_inc;
              if (run_ok_cur && ((nonempty_q & le_mask) == '0)) begin
                // New item would be popped straight back: hand it over directly
                inflight_d    = inflight_q + 1'b1;
                res_disp_d    = 1'b1;
                res_payload_d = PAYLOAD_WIDTH'(in_i.data.msg_payload);
                res_lvl_d     = in_lvl;
              end else begin
                disp_pend_d = run_ok_cur;
                state_d     = S_PUSH_RD;
              end
            end
          end else begin
            active_d   = act_dec;
            inflight_d = inflight_dec;
            if ((waiting_q != '0) && (nonempty_q != '0) && run_ok_dec) begin
              state_d = S_POP_HEAD;
            end
          end
        end
      end

      S_PUSH_RD: begin
        state_d = S_PUSH_WR;
      end

      S_PUSH_WR: begin
        pay_we  = 1'b1;
        tail_we = 1'b1;
        if (nonempty_q[prio_q]) begin
          next_we = 1'b1;
        end else begin
          head_we = 1'b1;
        end
        nonempty_d[prio_q] = 1'b1;
        rd_ptr_d           = rd_ptr_inc;
        waiting_d          = waiting_q + 1'b1;
        state_d            = disp_pend_q ? S_POP_HEAD : S_DONE;
      end

      S_POP_HEAD: begin
        lvl_d   = lvl_first;
        state_d = S_POP_SLOT;
      end

      S_POP_SLOT: begin
        // Return the head slot to the free ring
        ring_we   = 1'b1;
        wr_ptr_d  = wr_ptr_inc;
        if (wr_ptr_q == SlotW'(QUEUE_DEPTH - 1)) begin
          ring_full_d = 1'b1;
        end
        is_tail_d = (head_rdata == tail_rdata);
        state_d   = S_POP_WR;
      end

      S_POP_WR: begin
        res_disp_d    = 1'b1;
        res_payload_d = pay_rdata;
        res_lvl_d     = lvl_q;
        if (is_tail_q) begin
          nonempty_d[lvl_q] = 1'b0;
        end else begin
          head_we    = 1'b1;
          head_waddr = lvl_q;
          head_wdata = next_rdata;
        end
        waiting_d  = (waiting_q == '0) ? '0 : waiting_q - 1'b1;
        inflight_d = inflight_q + 1'b1;
        state_d    = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d              = 1'b1;
          out_data_d.status        = res_status_q;
          out_data_d.dispatched    = res_disp_q;
          out_data_d.out_payload   = PayloadPortW'(res_payload_q);
          out_data_d.out_priority  = PriorityOutW'(res_lvl_q);
          out_data_d.queued_count  = QueuedW'(waiting_q);
          out_data_d.running_count = inflight_q;
          out_data_d.idle_flag     = idle_now;
          state_d                  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      disp_ready_q   <= 1'b1;
      serial_q       <= 1'b1;
      max_inflight_q <= RunningW'(1);
      max_qsize_q    <= QueuedW'(256);
      nonempty_q     <= '0;
      rd_ptr_q       <= '0;
      wr_ptr_q       <= '0;
      ring_full_q    <= 1'b0;
      waiting_q      <= '0;
      inflight_q     <= '0;
      active_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      nonempty_q  <= nonempty_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      ring_full_q <= ring_full_d;
      waiting_q   <= waiting_d;
      inflight_q  <= inflight_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        unique case (cfg_i.data.index)
          RegDispatcherReady: disp_ready_q   <= cfg_i.data.value[0];
          RegSerialMode:      serial_q       <= cfg_i.data.value[0];
          RegMaxInflight:     max_inflight_q <= cfg_i.data.value[RunningW-1:0];
          RegMaxQueueSize:    max_qsize_q    <= cfg_i.data.value[QueuedW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q        <= prio_d;
    payload_q     <= payload_d;
    disp_pend_q   <= disp_pend_d;
    lvl_q         <= lvl_d;
    is_tail_q     <= is_tail_d;
    res_status_q  <= res_status_d;
    res_disp_q    <= res_disp_d;
    res_payload_q <= res_payload_d;
    res_lvl_q     <= res_lvl_d;
    out_data_q    <= out_data_d;
  end

  pmb_ram #(.Width(PAYLOAD_WIDTH), .Depth(QUEUE_DEPTH)) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .waddr_i (pay_waddr),
    .wdata_i (payload_q),
    .raddr_i (pay_raddr),
    .rdata_o (pay_rdata)
  );

  pmb_ram #(.Width(SlotW), .Depth(QUEUE_DEPTH)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (next_raddr),
    .rdata_o (next_rdata)
  );

  pmb_ram #(.Width(SlotW), .Depth(PRIORITY_LEVELS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (head_raddr),
    .rdata_o (head_rdata)
  );

  pmb_ram #(.Width(SlotW), .Depth(PRIORITY_LEVELS)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (tail_waddr),
    .wdata_i (tail_wdata),
    .raddr_i (tail_raddr),
    .rdata_o (tail_rdata)
  );

  pmb_ram #(.Width(SlotW), .Depth(QUEUE_DEPTH)) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

endmodule

`default_nettype wire
